[src/zpc_pkg.sv]
// Shared constants, types and control structs for the zero-padded 2D convolution unit.
// No dependencies; every other source file but zpc_ram imports this package.
package zpc_pkg;

    // Geometry
    localparam int KERNEL_DIM = 3;
    localparam int MAX_SIDE   = 1024;
    localparam int RADIUS     = KERNEL_DIM / 2;
    localparam int NCOEF      = KERNEL_DIM * KERNEL_DIM;

    // Field widths fixed by the stream format
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int CIDX_W      = 6;
    localparam int CFG_W       = 11;
    localparam int OUT_COORD_W = 10;

    // Derived widths
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int COL_W  = $clog2(MAX_SIDE);
    localparam int POS_W  = $clog2(MAX_SIDE * MAX_SIDE + RADIUS * MAX_SIDE + RADIUS + 1);
    localparam int LINES  = (KERNEL_DIM > 1) ? KERNEL_DIM - 1 : 1;
    localparam int LINE_W = LINES * PIX_W;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NCOEF);

    // Stream packing
    localparam int S_TDATA_W = ((PIX_W + CIDX_W + COEF_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PIX_W + 2 * OUT_COORD_W + 7) / 8) * 8;
    localparam int PIX_LSB   = 0;
    localparam int CIDX_LSB  = PIX_LSB + PIX_W;
    localparam int CVAL_LSB  = CIDX_LSB + CIDX_W;

    // Reset configuration
    localparam int SIDE_RESET  = 64;
    localparam int NN_RESET    = SIDE_RESET * SIDE_RESET;
    localparam int DELAY_RESET = RADIUS * SIDE_RESET + RADIUS;

    // Q14.22 sum back to Q8.8 with round half up, then clip
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'(32767);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(-32768);
    localparam logic [PIX_W-1:0] RES_MAX_BITS = 16'h7FFF;
    localparam logic [PIX_W-1:0] RES_MIN_BITS = 16'h8000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PIXEL = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_LOAD  = 2'd2
    } action_t;

    typedef logic [NCOEF-1:0][PIX_W-1:0]  pix_arr_t;
    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_arr_t;

    // Item held in the RAM read stage
    typedef struct packed {
        logic              is_load;
        logic              emit;
        logic              last;
        logic [PIX_W-1:0]  px;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  row_i;
        logic [COL_W-1:0]  col_j;
        logic [NCOEF-1:0]  mask;
        logic [CIDX_W-1:0] cidx;
        logic [COEF_W-1:0] cval;
    } s1_item_t;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] row_i;
        logic [COL_W-1:0] col_j;
    } meta_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             shift_en;
        logic [COL_W-1:0] wr_addr;
    } win_ctrl_t;

    typedef struct packed {
        logic adv_mul;
        logic adv_row;
    } mac_ctrl_t;

endpackage

[src/zpc_ram.sv]
// Generic simple dual-port RAM, one write and one read port, registered read.
// Read returns the old word when the same address is written in that cycle.
module zpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/zpc_window.sv]
// Line buffers in one RAM (all K-1 rows packed per column) plus the KxK window.
// Depends on zpc_pkg and zpc_ram.
module zpc_window import zpc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  win_ctrl_t        ctrl,
    input  logic [PIX_W-1:0] px,
    output pix_arr_t         window
);

    logic [LINE_W-1:0] rdata;
    logic [LINE_W-1:0] wdata;
    logic [LINE_W-1:0] line_data;
    logic [LINE_W-1:0] fwd_reg;
    logic              fwd_sel_reg;
    logic [KERNEL_DIM-1:0][PIX_W-1:0] slice;
    pix_arr_t          win_reg;
    pix_arr_t          win_next;

    zpc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_SIDE)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ctrl.shift_en),
        .waddr (ctrl.wr_addr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (rdata)
    );

    // A write to the column being read in the same cycle is missed by the RAM: forward it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_sel_reg <= 1'b0;
        end else if (ctrl.rd_en) begin
            fwd_sel_reg <= ctrl.shift_en && (ctrl.wr_addr == ctrl.rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            fwd_reg <= wdata;
        end
    end

    assign line_data = fwd_sel_reg ? fwd_reg : rdata;

    always_comb begin
        slice[0] = px;
        for (int m = 1; m < KERNEL_DIM; m++) begin
            slice[m] = line_data[(m-1)*PIX_W +: PIX_W];
        end
        // push the new pixel into the youngest line, age the others by one row
        wdata[0 +: PIX_W] = px;
        for (int l = 1; l < LINES; l++) begin
            wdata[l*PIX_W +: PIX_W] = line_data[(l-1)*PIX_W +: PIX_W];
        end
    end

    always_comb begin
        for (int ki = 0; ki < KERNEL_DIM; ki++) begin
            for (int kj = 0; kj < KERNEL_DIM; kj++) begin
                if (kj < KERNEL_DIM - 1) begin
                    win_next[ki*KERNEL_DIM + kj] = win_reg[ki*KERNEL_DIM + kj + 1];
                end else begin
                    win_next[ki*KERNEL_DIM + kj] = slice[KERNEL_DIM - 1 - ki];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            win_reg <= win_next;
        end
    end

    assign window = win_reg;

endmodule

[src/zpc_mac.sv]
// Multiply-accumulate datapath: masked products, per-row sums, final sum with rounding and clipping.
// Depends on zpc_pkg.
module zpc_mac import zpc_pkg::*; (
    input  logic             aclk,
    input  mac_ctrl_t        ctrl,
    input  pix_arr_t         window,
    input  coef_arr_t        coef,
    input  logic [NCOEF-1:0] mask,
    output logic [PIX_W-1:0] result,
    output logic             saturated
);

    logic [NCOEF-1:0][PROD_W-1:0]     prod_next;
    logic [NCOEF-1:0][PROD_W-1:0]     prod_reg;
    logic [KERNEL_DIM-1:0][ACC_W-1:0] row_next;
    logic [KERNEL_DIM-1:0][ACC_W-1:0] row_reg;
    logic signed [ACC_W-1:0]          total;
    logic signed [ACC_W:0]            biased;
    logic signed [ACC_W:0]            scaled;

    always_comb begin
        for (int k = 0; k < NCOEF; k++) begin
            if (mask[k]) begin
                prod_next[k] = $signed(window[k]) * $signed(coef[k]);
            end else begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv_mul) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] acc;
        for (int ki = 0; ki < KERNEL_DIM; ki++) begin
            acc = '0;
            for (int kj = 0; kj < KERNEL_DIM; kj++) begin
                acc = acc + ACC_W'($signed(prod_reg[ki*KERNEL_DIM + kj]));
            end
            row_next[ki] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv_row) begin
            row_reg <= row_next;
        end
    end

    always_comb begin
        total = '0;
        for (int ki = 0; ki < KERNEL_DIM; ki++) begin
            total = total + $signed(row_reg[ki]);
        end
        biased = (ACC_W + 1)'(total) + (ACC_W + 1)'(ROUND_BIAS);
        scaled = biased >>> FRAC_SHIFT;
        if (scaled > SAT_HI) begin
            result    = RES_MAX_BITS;
            saturated = 1'b1;
        end else if (scaled < SAT_LO) begin
            result    = RES_MIN_BITS;
            saturated = 1'b1;
        end else begin
            result    = scaled[PIX_W-1:0];
            saturated = 1'b0;
        end
    end

endmodule

[src/zero_padded_2d_convolution_unit.sv]
// Output (i,j) is completed by the beat R*n+R later, which then passes the read stage and
// window, product, row-sum and output registers to m_tvalid. Throughput: one beat per cycle
// unless m_tready stalls the output, set by the line RAM doing one read and one write a cycle.
// Reset (aresetn low, synchronous): stream position, kernel coefficients and pipeline
// valids clear, image size returns to 64; line RAM contents are left as they are.
module zero_padded_2d_convolution_unit import zpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: image_size
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel[15:0], coef_index[21:16], coef_value[37:22]
    input  logic [ACTION_W-1:0]  s_tuser,   // action[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result[15:0], out_row[25:16], out_col[35:26]
    output logic                 m_tlast,   // last
    output logic                 m_tuser    // saturated
);

    // configuration and stream position
    logic [SIDE_W-1:0] n_reg, n_next;
    logic [POS_W-1:0]  nn_reg, nn_next;
    logic [POS_W-1:0]  delay_reg, delay_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [COL_W-1:0]  out_i_reg, out_i_next;
    logic [COL_W-1:0]  out_j_reg, out_j_next;
    logic [SIDE_W-1:0] n_m1;
    logic [SIDE_W-1:0] n_cfg;
    logic [2*SIDE_W-1:0] nn_cfg;

    // input decode
    action_t          act;
    logic             s_acc;
    logic             cfg_acc;
    logic             in_stream;
    logic             in_load;
    logic             in_emit;
    logic             in_last;
    logic [KERNEL_DIM-1:0] row_ok;
    logic [KERNEL_DIM-1:0] col_ok;
    s1_item_t         s1_next;

    // pipeline
    s1_item_t         s1_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t            meta2_reg, meta3_reg, meta4_reg;
    logic [NCOEF-1:0] mask2_reg;
    logic             rdy1, rdy2, rdy3, rdy4, rdy_m;
    coef_arr_t        coef_reg;
    pix_arr_t         window;
    win_ctrl_t        win_ctrl;
    mac_ctrl_t        mac_ctrl;
    logic [PIX_W-1:0] mac_result;
    logic             mac_sat;

    // output register
    logic                   m_valid_reg;
    logic [PIX_W-1:0]       m_res_reg;
    logic [OUT_COORD_W-1:0] m_row_reg;
    logic [OUT_COORD_W-1:0] m_col_reg;
    logic                   m_last_reg;
    logic                   m_sat_reg;

    // handshake chain: a stage takes a new beat when empty or when it hands its own on
    assign rdy_m     = !m_valid_reg || m_tready;
    assign rdy4      = !v4_reg || rdy_m;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_tready  = rdy1;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign act       = action_t'(s_tuser);
    assign in_stream = (act == ACT_PIXEL) || (act == ACT_FLUSH);
    assign in_load   = (act == ACT_LOAD);
    assign n_m1      = n_reg - SIDE_W'(1);
    assign in_emit   = in_stream && (pos_reg >= delay_reg);
    assign in_last   = in_emit && (SIDE_W'(out_i_reg) == n_m1) && (SIDE_W'(out_j_reg) == n_m1);

    // zero padding: mark window taps that fall inside the image
    always_comb begin
        logic [SIDE_W:0] ri;
        logic [SIDE_W:0] cj;
        for (int k = 0; k < KERNEL_DIM; k++) begin
            ri = (SIDE_W + 1)'(out_i_reg) + (SIDE_W + 1)'(k);
            cj = (SIDE_W + 1)'(out_j_reg) + (SIDE_W + 1)'(k);
            row_ok[k] = (ri >= (SIDE_W + 1)'(RADIUS))
                     && (ri < (SIDE_W + 1)'(n_reg) + (SIDE_W + 1)'(RADIUS));
            col_ok[k] = (cj >= (SIDE_W + 1)'(RADIUS))
                     && (cj < (SIDE_W + 1)'(n_reg) + (SIDE_W + 1)'(RADIUS));
        end
    end

    always_comb begin
        s1_next.is_load = in_load;
        s1_next.emit    = in_emit;
        s1_next.last    = in_last;
        s1_next.px      = ((act == ACT_PIXEL) && (pos_reg < nn_reg))
                          ? s_tdata[PIX_LSB +: PIX_W] : '0;
        s1_next.col     = in_col_reg;
        s1_next.row_i   = out_i_reg;
        s1_next.col_j   = out_j_reg;
        for (int ki = 0; ki < KERNEL_DIM; ki++) begin
            for (int kj = 0; kj < KERNEL_DIM; kj++) begin
                s1_next.mask[ki*KERNEL_DIM + kj] = row_ok[ki] && col_ok[kj];
            end
        end
        s1_next.cidx    = s_tdata[CIDX_LSB +: CIDX_W];
        s1_next.cval    = s_tdata[CVAL_LSB +: COEF_W];
    end

    // clamp a written size into 1..MAX_SIDE
    always_comb begin
        if (cfg_data == '0) begin
            n_cfg = SIDE_W'(1);
        end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
            n_cfg = SIDE_W'(MAX_SIDE);
        end else begin
            n_cfg = SIDE_W'(cfg_data);
        end
        nn_cfg = (2 * SIDE_W)'(n_cfg) * (2 * SIDE_W)'(n_cfg);
    end

    always_comb begin
        n_next      = n_reg;
        nn_next     = nn_reg;
        delay_next  = delay_reg;
        pos_next    = pos_reg;
        in_col_next = in_col_reg;
        out_i_next  = out_i_reg;
        out_j_next  = out_j_reg;
        if (cfg_acc) begin
            n_next      = n_cfg;
            nn_next     = POS_W'(nn_cfg);
            delay_next  = POS_W'(RADIUS * n_cfg + RADIUS);
            pos_next    = '0;
            in_col_next = '0;
            out_i_next  = '0;
            out_j_next  = '0;
        end else if (s_acc && in_stream) begin
            if (in_last) begin
                pos_next    = '0;
                in_col_next = '0;
                out_i_next  = '0;
                out_j_next  = '0;
            end else begin
                pos_next    = pos_reg + POS_W'(1);
                in_col_next = (SIDE_W'(in_col_reg) == n_m1) ? '0 : in_col_reg + COL_W'(1);
                if (in_emit) begin
                    if (SIDE_W'(out_j_reg) == n_m1) begin
                        out_j_next = '0;
                        out_i_next = out_i_reg + COL_W'(1);
                    end else begin
                        out_j_next = out_j_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg      <= SIDE_W'(SIDE_RESET);
            nn_reg     <= POS_W'(NN_RESET);
            delay_reg  <= POS_W'(DELAY_RESET);
            pos_reg    <= '0;
            in_col_reg <= '0;
            out_i_reg  <= '0;
            out_j_reg  <= '0;
        end else begin
            n_reg      <= n_next;
            nn_reg     <= nn_next;
            delay_reg  <= delay_next;
            pos_reg    <= pos_next;
            in_col_reg <= in_col_next;
            out_i_reg  <= out_i_next;
            out_j_reg  <= out_j_next;
        end
    end

    // valids; unused action codes are taken and dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_acc && (in_stream || in_load);
            end
            if (rdy2) begin
                v2_reg <= v1_reg && s1_reg.emit;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy_m) begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            meta2_reg.last  <= s1_reg.last;
            meta2_reg.row_i <= s1_reg.row_i;
            meta2_reg.col_j <= s1_reg.col_j;
            mask2_reg       <= s1_reg.mask;
        end
        if (rdy3) begin
            meta3_reg <= meta2_reg;
        end
        if (rdy4) begin
            meta4_reg <= meta3_reg;
        end
        if (v4_reg && rdy_m) begin
            m_res_reg  <= mac_result;
            m_sat_reg  <= mac_sat;
            m_row_reg  <= OUT_COORD_W'(meta4_reg.row_i);
            m_col_reg  <= OUT_COORD_W'(meta4_reg.col_j);
            m_last_reg <= meta4_reg.last;
        end
    end

    // coefficient loads take effect in stream order, as they leave the read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (v1_reg && s1_reg.is_load && rdy2) begin
            for (int k = 0; k < NCOEF; k++) begin
                if (CIDX_W'(k) == s1_reg.cidx) begin
                    coef_reg[k] <= s1_reg.cval;
                end
            end
        end
    end

    always_comb begin
        win_ctrl.rd_en    = s_acc && in_stream;
        win_ctrl.rd_addr  = in_col_reg;
        win_ctrl.shift_en = v1_reg && !s1_reg.is_load && rdy2;
        win_ctrl.wr_addr  = s1_reg.col;
        mac_ctrl.adv_mul  = v2_reg && rdy3;
        mac_ctrl.adv_row  = v3_reg && rdy4;
    end

    zpc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .px      (s1_reg.px),
        .window  (window)
    );

    zpc_mac u_mac (
        .aclk      (aclk),
        .ctrl      (mac_ctrl),
        .window    (window),
        .coef      (coef_reg),
        .mask      (mask2_reg),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PIX_W - 2 * OUT_COORD_W){1'b0}},
                       m_col_reg, m_row_reg, m_res_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    // the stream position never runs past the final output of the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < nn_reg + delay_reg)
        else $error("stream position beyond end of frame");

    // input is only held off while the read stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg)
        else $error("input stalled with empty read stage");

    // the last pixel of a frame has equal row and column, as the bottom-right corner does
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_row_reg == m_col_reg))
        else $error("last beat not on the diagonal corner");

    // output row counter stays inside the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        SIDE_W'(out_i_reg) < n_reg)
        else $error("output row counter out of range");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for zero_padded_2d_convolution_unit: loads kernels, streams images
// of many sizes and compares every output pixel with a scoreboard's own convolution.
// Depends on zpc_pkg and the unit's RTL only.

import zpc_pkg::*;

// pixel history: two lines plus the window tail, folded into one ring
localparam int PIX_HIST_LEN = 2 * RADIUS * MAX_SIDE + 2 * RADIUS + 1;
localparam int MAX_REPORTS  = 100;
localparam int OUT_ROW_LSB  = PIX_W;
localparam int OUT_COL_LSB  = PIX_W + OUT_COORD_W;

typedef struct packed {
    logic [PIX_W-1:0]       value;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] col;
    logic                   last;
    logic                   sat;
} out_pixel_t;

typedef enum int {
    COEF_FULL,
    COEF_SMALL,
    COEF_EXTREME
} coef_mix_t;

class conv_scoreboard;
    logic signed [PIX_W-1:0]  pix_hist [PIX_HIST_LEN];
    logic signed [COEF_W-1:0] kernel [NCOEF];
    int unsigned side;
    int unsigned row_at;
    int unsigned col_at;
    int unsigned hist_ptr;
    out_pixel_t  awaited[$];
    int          mismatches;

    function new();
        foreach (pix_hist[k]) pix_hist[k] = '0;
        foreach (kernel[k]) kernel[k] = '0;
        side       = SIDE_RESET;
        mismatches = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        row_at   = 0;
        col_at   = 0;
        hist_ptr = 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void set_side(logic [CFG_W-1:0] v);
        side = v;
        if (side < 1) side = 1;
        if (side > MAX_SIDE) side = MAX_SIDE;
        restart_frame();
    endfunction

    // Note one accepted input beat and queue the output pixel it completes, if any.
    function void take_beat(logic [ACTION_W-1:0] act, logic [S_TDATA_W-1:0] d);
        logic [CIDX_W-1:0]       ci;
        logic signed [PIX_W-1:0] px;
        int unsigned             n, lag, pos, q, oi, oj, lin, idx;
        int                      ns, ii, jj;
        longint                  acc, r;
        out_pixel_t              e;
        n   = side;
        ns  = int'(n);
        lag = RADIUS * n + RADIUS;
        if (act == ACT_LOAD) begin
            ci = d[CIDX_LSB +: CIDX_W];
            if (ci < NCOEF) kernel[ci] = d[CVAL_LSB +: COEF_W];
            return;
        end
        if (act != ACT_PIXEL && act != ACT_FLUSH) return;

        pos = row_at * n + col_at;
        px  = (act == ACT_PIXEL && pos < n * n) ? d[PIX_LSB +: PIX_W] : '0;
        pix_hist[hist_ptr] = px;
        col_at++;
        if (col_at >= n) begin
            col_at = 0;
            row_at++;
        end
        if (pos < lag || pos - lag >= n * n) begin
            hist_ptr = (hist_ptr + 1) % PIX_HIST_LEN;
            return;
        end

        q   = pos - lag;
        oi  = q / n;
        oj  = q % n;
        acc = 0;
        for (int ki = 0; ki < KERNEL_DIM; ki++) begin
            for (int kj = 0; kj < KERNEL_DIM; kj++) begin
                ii = int'(oi) + ki - RADIUS;
                jj = int'(oj) + kj - RADIUS;
                if (ii >= 0 && ii < ns && jj >= 0 && jj < ns) begin
                    lin = ii * ns + jj;
                    idx = (hist_ptr + PIX_HIST_LEN - (pos - lin) % PIX_HIST_LEN) % PIX_HIST_LEN;
                    acc += longint'(pix_hist[idx]) * longint'(kernel[ki * KERNEL_DIM + kj]);
                end
            end
        end

        // round half up to Q8.8, then clip
        r     = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
        e.sat = 1'b0;
        if (r > 32767) begin
            r     = 32767;
            e.sat = 1'b1;
        end else if (r < -32768) begin
            r     = -32768;
            e.sat = 1'b1;
        end
        e.value = r[PIX_W-1:0];
        e.row   = OUT_COORD_W'(oi);
        e.col   = OUT_COORD_W'(oj);
        e.last  = (q == n * n - 1);
        awaited.push_back(e);
        if (e.last)
            restart_frame();
        else
            hist_ptr = (hist_ptr + 1) % PIX_HIST_LEN;
    endfunction

    task report_mismatch(string what);
        if (mismatches < MAX_REPORTS) $display("[%0t] ERROR: %s", $time, what);
        mismatches++;
    endtask

    task check_pixel(logic [M_TDATA_W-1:0] d, logic lst, logic sat);
        out_pixel_t             e;
        logic [PIX_W-1:0]       value;
        logic [OUT_COORD_W-1:0] row, col;
        value = d[0 +: PIX_W];
        row   = d[OUT_ROW_LSB +: OUT_COORD_W];
        col   = d[OUT_COL_LSB +: OUT_COORD_W];
        if (awaited.size() == 0) begin
            report_mismatch($sformatf("output beat (%0d,%0d) with no pixel awaited", row, col));
            return;
        end
        e = awaited.pop_front();
        if (value !== e.value)
            report_mismatch($sformatf("pixel (%0d,%0d) value %h, want %h",
                                      e.row, e.col, value, e.value));
        if (row !== e.row)
            report_mismatch($sformatf("pixel (%0d,%0d) row %0d", e.row, e.col, row));
        if (col !== e.col)
            report_mismatch($sformatf("pixel (%0d,%0d) column %0d", e.row, e.col, col));
        if (lst !== e.last)
            report_mismatch($sformatf("pixel (%0d,%0d) tlast %b, want %b",
                                      e.row, e.col, lst, e.last));
        if (sat !== e.sat)
            report_mismatch($sformatf("pixel (%0d,%0d) saturation flag %b, want %b",
                                      e.row, e.col, sat, e.sat));
    endtask
endclass

module tb;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int TAIL_CYCLES  = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 560;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACTION_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int stream_beats  = 0;
    int quiet_cycles  = 0;

    conv_scoreboard sb = new();

    zero_padded_2d_convolution_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_side(cfg_data);
            if (s_tvalid && s_tready) sb.take_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast, m_tuser);
        end
    end

    // end the run once nothing has moved on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(coef_mix_t mix);
        case (mix)
            COEF_FULL:  return 16'($urandom);
            COEF_SMALL: return 16'($urandom_range(4095)) - 16'd2048;
            default: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned frame_beats(int unsigned n);
        return n * n + RADIUS * n + RADIUS;
    endfunction

    task automatic send_beat(logic [ACTION_W-1:0] act, logic [PIX_W-1:0] px,
                             logic [CIDX_W-1:0] ci, logic [COEF_W-1:0] cv);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[PIX_LSB +: PIX_W]   = px;
        d[CIDX_LSB +: CIDX_W] = ci;
        d[CVAL_LSB +: COEF_W] = cv;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_PIXEL || act == ACT_FLUSH) stream_beats++;
    endtask

    task automatic send_pixel(logic [ACTION_W-1:0] act, logic [PIX_W-1:0] px);
        send_beat(act, px, CIDX_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic send_coef(logic [CIDX_W-1:0] ci, logic [COEF_W-1:0] cv);
        send_beat(ACT_LOAD, PIX_W'($urandom), ci, cv);
    endtask

    task automatic load_kernel(coef_mix_t mix);
        for (int k = 0; k < NCOEF; k++) send_coef(CIDX_W'(k), rand_coef(mix));
    endtask

    // hold the stream until every awaited pixel is out, then let the pipe empty;
    // first let the clock advance so the beat just accepted has been noted
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_side(logic [CFG_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stream stop_at beats of an n-by-n frame; a full frame also drains its last rows.
    task automatic run_frame(int unsigned n, int unsigned stop_at, bit pause_once);
        int unsigned         hold_at;
        logic [ACTION_W-1:0] act;
        hold_at = $urandom_range(stop_at - 1);
        for (int unsigned k = 0; k < stop_at; k++) begin
            if ($urandom_range(99) < 3)
                send_coef(($urandom_range(3) == 0) ? CIDX_W'($urandom_range(63))
                                                   : CIDX_W'($urandom_range(NCOEF - 1)),
                          rand_coef(coef_mix_t'($urandom_range(2))));
            if ($urandom_range(99) == 0)
                send_beat(ACT_SPARE, PIX_W'($urandom), CIDX_W'($urandom), COEF_W'($urandom));
            if (pause_once && k == hold_at)
                settle();
            if (k < n * n)
                act = ($urandom_range(99) < 8) ? ACT_FLUSH : ACT_PIXEL;
            else
                act = $urandom_range(1) ? ACT_FLUSH : ACT_PIXEL;
            send_pixel(act, rand_pixel());
        end
    endtask

    initial begin
        int unsigned n;
        int          frames, phase;
        bit          cut;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // kernel at both extremes, loads past the kernel, an unused action
        for (int k = 0; k < NCOEF; k++)
            send_coef(CIDX_W'(k), (k % 2) ? 16'h8000 : 16'h7FFF);
        send_coef(CIDX_W'(NCOEF), 16'h1234);
        send_coef(6'h3F, 16'hFFFF);
        send_beat(ACT_SPARE, 16'h7FFF, 6'h3F, 16'hFFFF);

        // just over one row (80 beats) at the side length left by reset
        run_frame(SIDE_RESET, 80, 1'b0);

        // zero reads as one; the third beat lies past the image and acts as a flush
        write_side('0);
        send_pixel(ACT_PIXEL, 16'h7FFF);
        send_pixel(ACT_FLUSH, 16'h7FFF);
        send_pixel(ACT_PIXEL, 16'h8000);

        // 2x2 with a flush standing in for an image pixel
        write_side(CFG_W'(2));
        send_pixel(ACT_PIXEL, 16'h8000);
        send_pixel(ACT_FLUSH, 16'h1234);
        send_pixel(ACT_PIXEL, 16'h0001);
        send_pixel(ACT_PIXEL, 16'hFFFF);
        send_pixel(ACT_FLUSH, 16'h0000);
        send_pixel(ACT_PIXEL, 16'h7FFF);
        send_pixel(ACT_FLUSH, 16'h8000);

        phase = 0;
        while (stream_beats < RANDOM_BEATS) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
                default: begin src_idle_pct = 28; snk_stall_pct = 28; end
            endcase
            n = ($urandom_range(99) < 70) ? $urandom_range(6, 1) : $urandom_range(16, 7);
            write_side(CFG_W'(n));
            load_kernel(coef_mix_t'($urandom_range(2)));
            frames = $urandom_range(3, 1);
            cut    = 1'b0;
            for (int f = 0; f < frames && !cut; f++) begin
                if ($urandom_range(99) < 15) begin
                    // broken frame: stop short, the next size write restarts the stream
                    run_frame(n, $urandom_range(frame_beats(n) - 1, 1), 1'b0);
                    cut = 1'b1;
                end else begin
                    run_frame(n, frame_beats(n), (f == 0) && (phase % 2 == 0));
                end
            end
            phase++;
        end

        // an oversized write clips to the largest side; stream a short first row
        src_idle_pct  = 28;
        snk_stall_pct = 28;
        write_side('1);
        load_kernel(COEF_SMALL);
        run_frame(MAX_SIDE, 64, 1'b1);

        settle();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[filelist.f]
src/zpc_pkg.sv
src/zpc_ram.sv
src/zpc_window.sv
src/zpc_mac.sv
src/zero_padded_2d_convolution_unit.sv
bench/tb.sv
